@@ src/utf8v_pkg.sv @@
// Package for the UTF-8 stream validator: decoder state type, item types
// and the code point limits. No dependencies.
`default_nettype none

package utf8v_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CODE_W = 21;

   // Lead byte patterns and masks.
   localparam logic [7:0] ASCII_LIMIT  = 8'h80;
   localparam logic [7:0] LEAD2_LO     = 8'hC0;
   localparam logic [7:0] LEAD2_HI     = 8'hDF;
   localparam logic [7:0] LEAD3_LO     = 8'hE0;
   localparam logic [7:0] LEAD3_HI     = 8'hEF;
   localparam logic [7:0] LEAD4_LO     = 8'hF0;
   localparam logic [7:0] LEAD4_HI     = 8'hF7;
   localparam logic [7:0] CONT_MASK    = 8'hC0;
   localparam logic [7:0] CONT_PATTERN = 8'h80;

   // Code point limits.
   localparam logic [CODE_W-1:0] MIN_CLASS1 = 21'h000080;
   localparam logic [CODE_W-1:0] MIN_CLASS2 = 21'h000800;
   localparam logic [CODE_W-1:0] MIN_CLASS3 = 21'h010000;
   localparam logic [CODE_W-1:0] CODE_MAX   = 21'h10FFFF;
   localparam logic [CODE_W-1:0] SURR_LO    = 21'h00D800;
   localparam logic [CODE_W-1:0] SURR_HI    = 21'h00DFFF;

   // Sequence length classes.
   localparam logic [1:0] CLASS_NONE = 2'd0;
   localparam logic [1:0] CLASS_TWO  = 2'd1;
   localparam logic [1:0] CLASS_THREE = 2'd2;
   localparam logic [1:0] CLASS_FOUR = 2'd3;

   typedef struct packed {
      logic [1:0]        bytes_owed;
      logic [CODE_W-1:0] partial_code;
      logic [1:0]        length_class;
      logic              fault_seen;
   } dec_state_type;

   typedef struct packed {
      logic              vld;
      logic [BYTE_W-1:0] data_byte;
      logic              final_byte;
   } in_item_type;

   typedef struct packed {
      dec_state_type next_state;
      logic          text_valid;
   } dec_result_type;

   function automatic logic [CODE_W-1:0] class_minimum(input logic [1:0] cls);
      logic [CODE_W-1:0] m;
      case (cls)
         CLASS_TWO:   m = MIN_CLASS1;
         CLASS_THREE: m = MIN_CLASS2;
         default:     m = MIN_CLASS3;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

@@ src/utf8v_in_stage.sv @@
// Input register of the UTF-8 stream validator: holds one byte transaction
// until the decoder takes it. Depends on utf8v_pkg.
`default_nettype none

module utf8v_in_stage
   import utf8v_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [BYTE_W-1:0] req_data_byte,
   input  wire logic              req_final_byte,
   input  wire logic              advance,
   output in_item_type            item
);

   logic              vld_ff;
   logic              vld_in;
   logic [BYTE_W-1:0] data_ff;
   logic              final_ff;
   logic              load;

   assign req_ready = !vld_ff || advance;
   assign load      = req_valid && req_ready;
   assign vld_in    = load ? 1'b1 : (advance ? 1'b0 : vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff  <= req_data_byte;
         final_ff <= req_final_byte;
      end
   end

   assign item.vld        = vld_ff;
   assign item.data_byte  = data_ff;
   assign item.final_byte = final_ff;

endmodule

`default_nettype wire

@@ src/utf8v_decode.sv @@
// Byte decoder of the UTF-8 stream validator: next running state and the
// verdict for one byte. Purely combinational. Depends on utf8v_pkg.
`default_nettype none

module utf8v_decode
   import utf8v_pkg::*;
(
   input  dec_state_type          cur_state,
   input  wire logic [BYTE_W-1:0] data_byte,
   output dec_result_type         result
);

   logic [CODE_W-1:0] shifted;
   logic [1:0]        owed_dec;
   logic              is_cont;
   dec_state_type     nxt;

   assign shifted  = {cur_state.partial_code[CODE_W-7:0], data_byte[5:0]};
   assign owed_dec = cur_state.bytes_owed - 2'd1;
   assign is_cont  = (data_byte & CONT_MASK) == CONT_PATTERN;

   always_comb begin
      nxt = cur_state;
      if (cur_state.bytes_owed != 2'd0) begin
         if (!is_cont) begin
            // The sequence is abandoned; this byte is not decoded further.
            nxt.fault_seen   = 1'b1;
            nxt.bytes_owed   = 2'd0;
            nxt.partial_code = '0;
            nxt.length_class = CLASS_NONE;
         end else begin
            nxt.partial_code = shifted;
            nxt.bytes_owed   = owed_dec;
            if (owed_dec == 2'd0) begin
               if (shifted < class_minimum(cur_state.length_class) ||
                   shifted > CODE_MAX ||
                   shifted inside {[SURR_LO:SURR_HI]}) begin
                  nxt.fault_seen = 1'b1;
               end
               nxt.partial_code = '0;
               nxt.length_class = CLASS_NONE;
            end
         end
      end else begin
         if (data_byte == '0) begin
            nxt.fault_seen = 1'b1;
         end else if (data_byte < ASCII_LIMIT) begin
            nxt = cur_state;
         end else if (data_byte inside {[LEAD2_LO:LEAD2_HI]}) begin
            nxt.bytes_owed   = 2'd1;
            nxt.length_class = CLASS_TWO;
            nxt.partial_code = {{(CODE_W-5){1'b0}}, data_byte[4:0]};
         end else if (data_byte inside {[LEAD3_LO:LEAD3_HI]}) begin
            nxt.bytes_owed   = 2'd2;
            nxt.length_class = CLASS_THREE;
            nxt.partial_code = {{(CODE_W-4){1'b0}}, data_byte[3:0]};
         end else if (data_byte inside {[LEAD4_LO:LEAD4_HI]}) begin
            nxt.bytes_owed   = 2'd3;
            nxt.length_class = CLASS_FOUR;
            nxt.partial_code = {{(CODE_W-3){1'b0}}, data_byte[2:0]};
         end else begin
            nxt.fault_seen = 1'b1;
         end
      end
   end

   assign result.next_state = nxt;
   assign result.text_valid = !nxt.fault_seen && (nxt.bytes_owed == 2'd0);

endmodule

`default_nettype wire

@@ src/utf8v_out_stage.sv @@
// Result register of the UTF-8 stream validator: holds one verdict until the
// receiver takes it. Depends on utf8v_pkg.
`default_nettype none

module utf8v_out_stage
   import utf8v_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic load,
   input  wire logic text_valid,
   output logic      out_free,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output logic      rsp_text_valid
);

   logic valid_ff;
   logic valid_in;
   logic text_valid_ff;

   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         text_valid_ff <= text_valid;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_text_valid = text_valid_ff;

endmodule

`default_nettype wire

@@ src/utf8_stream_validator_top.sv @@
// UTF-8 stream validator, top level: input register, running decoder state,
// byte decoder and result register. Depends on utf8v_pkg and its submodules.
//
// The text arrives one byte per req_ transaction, with req_final_byte set on
// its last byte. Every byte updates the running decoder state; only the final
// byte produces a rsp_ transaction, whose rsp_text_valid is 1 when the whole
// text was well-formed UTF-8 without zero bytes. The state then clears and the
// next byte starts a new text.
// Throughput is one byte per cycle unless a final byte stalls. A byte is held
// in the input register, decoded against the running state and, if final,
// its verdict is written into the result register, which drives rsp_valid.
// A stalled receiver blocks only final bytes; non-final bytes keep flowing
// while a verdict waits. When a final byte waits behind an untaken verdict,
// req_ready drops after the input register.
// Synchronous reset empties both registers and clears the decoder state.
`default_nettype none

module utf8_stream_validator_top
   import utf8v_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [BYTE_W-1:0] req_data_byte,
   input  wire logic              req_final_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_text_valid
);

   in_item_type    item;
   dec_result_type dec;
   dec_state_type  state_ff;
   dec_state_type  state_in;
   logic           out_free;
   logic           advance;

   assign advance = item.vld && (!item.final_byte || out_free);

   utf8v_in_stage u_in_stage (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .advance        (advance),
      .item           (item)
   );

   utf8v_decode u_decode (
      .cur_state (state_ff),
      .data_byte (item.data_byte),
      .result    (dec)
   );

   // After the final byte of a text all state returns to zero.
   always_comb begin
      state_in = state_ff;
      if (advance) begin
         state_in = item.final_byte ? '0 : dec.next_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   utf8v_out_stage u_out_stage (
      .clock          (clock),
      .reset          (reset),
      .load           (advance && item.final_byte),
      .text_valid     (dec.text_valid),
      .out_free       (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_text_valid (rsp_text_valid)
   );

endmodule

`default_nettype wire

@@ src/utf8v_checker.sv @@
// Port-level checker for the UTF-8 stream validator, bound to the top level.
// Depends on utf8_stream_validator_top's port list only.
`default_nettype none

module utf8v_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_text_valid
);

   // A verdict that is not taken stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_text_valid))
      else $error("verdict changed or vanished while stalled");

   // Reset leaves no verdict pending and the input open.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // With the result register empty, nothing can block the input.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with no verdict pending");

endmodule

bind utf8_stream_validator_top utf8v_checker u_utf8v_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_text_valid (rsp_text_valid)
);

`default_nettype wire
